// ===== rtl/sus_pkg.sv =====
package sus_pkg;

    localparam int VALUE_W = 31;
    localparam int INDEX_W = 6;
    localparam int TOTAL_W = 7;
    localparam int READ_REACH = 1 << INDEX_W;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               lt;
    } t_link;

    typedef struct packed {
        logic               shift_en;
        logic [VALUE_W-1:0] key;
    } t_cell_ctl;

endpackage

// ===== rtl/sus_cell.sv =====
module sus_cell (
    input  logic               i_clk,
    input  sus_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  sus_pkg::t_link     i_prev,
    output sus_pkg::t_link     o_link,
    output logic               o_eq
);
    import sus_pkg::*;

    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] n_val;
    logic               lt;

    always_comb begin
        lt    = i_valid && (r_val < i_ctl.key);
        o_eq  = i_valid && (r_val == i_ctl.key);
        n_val = r_val;
        if (i_ctl.shift_en && !lt) begin
            n_val = i_prev.lt ? i_ctl.key : i_prev.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link.value = r_val;
    assign o_link.lt    = lt;

endmodule

// ===== rtl/sorted_unique_set_insert_unit.sv =====
// channel   direction  transfer when         fields
// command   in         start && !busy       i_kind, i_value, i_index
// result    out        o_done (one cycle)   o_was_new, o_was_full, o_position,
//                                           o_entry_total, o_read_value, o_read_valid
//
// In a command, busy is high for the cycle after the transfer, while every cell compares
// the key in parallel and, for a new insert, shifts; the result strobes in the next.
// A new command may be transferred in the cycle its predecessor's result is shown.
// Reset (synchronous, active low) empties the set; cell contents are not cleared.
// The receiver cannot stall: o_done is high for exactly one cycle.
module sorted_unique_set_insert_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_kind,
    input  logic [sus_pkg::VALUE_W-1:0]     i_value,
    input  logic [sus_pkg::INDEX_W-1:0]     i_index,
    output logic                            o_done,
    output logic                            o_was_new,
    output logic                            o_was_full,
    output logic [sus_pkg::TOTAL_W-1:0]     o_position,
    output logic [sus_pkg::TOTAL_W-1:0]     o_entry_total,
    output logic [sus_pkg::VALUE_W-1:0]     o_read_value,
    output logic                            o_read_valid
);
    import sus_pkg::*;

    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int RD_CELLS = (CAPACITY < READ_REACH) ? CAPACITY : READ_REACH;

    logic               r_go;
    t_kind              r_kind;
    logic [VALUE_W-1:0] r_value;
    logic [INDEX_W-1:0] r_index;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    t_cell_ctl          ctl;
    t_link              links [CAPACITY+1];
    logic [CAPACITY-1:0] eq;
    logic [CAPACITY-1:0] cell_valid;

    logic               dup;
    logic               full;
    logic               do_insert;
    logic [CW-1:0]      pos;
    logic [VALUE_W-1:0] rd_val;
    logic               rd_hit;

    logic               n_was_new;
    logic               n_was_full;
    logic [CW-1:0]      n_position;
    logic [VALUE_W-1:0] n_read_value;
    logic               n_read_valid;

    assign busy = r_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= start && !busy;
        end
        if (start && !busy) begin
            r_kind  <= t_kind'(i_kind);
            r_value <= i_value;
            r_index <= i_index;
        end
    end

    assign links[0].value = r_value;
    assign links[0].lt    = 1'b1;

    assign dup       = |eq;
    assign full      = (r_count >= CW'(CAPACITY));
    assign do_insert = r_go && (r_kind == KIND_INSERT) && !dup && !full;

    assign ctl.shift_en = do_insert;
    assign ctl.key      = r_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign cell_valid[g] = (CW'(g) < r_count);
        sus_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_valid (cell_valid[g]),
            .i_prev  (links[g]),
            .o_link  (links[g+1]),
            .o_eq    (eq[g])
        );
    end

    always_comb begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (links[i].lt && !links[i+1].lt) begin
                pos = pos | CW'(i);
            end
        end
        if (links[CAPACITY].lt) begin
            pos = CW'(CAPACITY);
        end
    end

    always_comb begin
        rd_val = '0;
        rd_hit = 1'b0;
        for (int i = 0; i < RD_CELLS; i++) begin
            if (cell_valid[i] && (r_index == INDEX_W'(i))) begin
                rd_val = rd_val | links[i+1].value;
                rd_hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_count      = r_count;
        n_was_new    = 1'b0;
        n_was_full   = 1'b0;
        n_position   = '0;
        n_read_value = '0;
        n_read_valid = 1'b0;
        case (r_kind)
            KIND_INSERT: begin
                n_position = pos;
                n_was_new  = !dup && !full;
                n_was_full = !dup && full;
                if (!dup && !full) begin
                    n_count = r_count + CW'(1);
                end
            end
            KIND_READ: begin
                n_read_valid = rd_hit;
                n_read_value = rd_val;
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= r_go;
            if (r_go) begin
                r_count <= n_count;
            end
        end
        if (r_go) begin
            o_was_new     <= n_was_new;
            o_was_full    <= n_was_full;
            o_position    <= TOTAL_W'(n_position);
            o_entry_total <= TOTAL_W'(n_count);
            o_read_value  <= n_read_value;
            o_read_valid  <= n_read_valid;
        end
    end

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |=> !r_go) else $error("busy held longer than one cycle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |=> o_done) else $error("result strobe missing after command");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_was_new && o_was_full)) else $error("new and full both set");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> r_count == $past(r_count) + CW'(1))
        else $error("count not advanced on insert");

    a_single_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> $onehot0(eq)) else $error("value held in more than one cell");

endmodule
